### sv/gfp_pkg.sv
// ----------------------------------------------------------------------------
// gfp_pkg
// Shared types, constants and the FNV-1a mix function of the graph
// fingerprinter.
// ----------------------------------------------------------------------------
package gfp_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

  localparam int          MAX_NODES  = 65535;
  localparam logic [15:0] NODE_LIMIT = (MAX_NODES < 65535) ? 16'(MAX_NODES) : 16'hFFFF;

  localparam int QUEUE_DEPTH = 4;

  // ASCII characters of the formatted text
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // reciprocal of ten for a 32-bit dividend, quotient = (v * RECIP10) >> 35
  localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;

  typedef enum logic [2:0] {
    OP_BEGIN      = 3'd0,
    OP_NODE       = 3'd1,
    OP_COORD      = 3'd2,
    OP_CONSTRAINT = 3'd3,
    OP_FINISH     = 3'd4
  } op_code_t;

  typedef enum logic [2:0] {
    CMD_BEGIN,
    CMD_NODE,
    CMD_BYTE,
    CMD_CONSTRAINT,
    CMD_FINISH
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t   code;
    logic [31:0] id;
    logic [7:0]  kind;
    logic        coord;  // node text goes on with a coordinate
    logic [7:0]  data;   // coordinate byte
    logic        mix;    // coordinate byte is hashed
    logic        last;   // coordinate ends here
  } fp_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHAR_C,
    ST_COLON_A,
    ST_MINUS,
    ST_DIV,
    ST_DIGIT,
    ST_SEP,
    ST_TAIL,
    ST_FOLD,
    ST_OUT
  } back_state_t;

  // (h ^ x) * prime mod 2^64, prime = 2^40 + 0x1B3
  function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [63:0] x);
    logic [63:0] v;
    v = h ^ x;
    return v + (v << 1) + (v << 4) + (v << 5) + (v << 7) + (v << 8) + (v << 40);
  endfunction

endpackage

### sv/gfp_queue.sv
// ----------------------------------------------------------------------------
// gfp_queue
// Short command queue between the front classifier and the back sequencer.
// ----------------------------------------------------------------------------
module gfp_queue #(
  parameter int DEPTH = gfp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  gfp_pkg::fp_cmd_t push_cmd,
  output logic             full,
  output logic             valid,
  input  logic             pop,
  output gfp_pkg::fp_cmd_t pop_cmd
);
  import gfp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fp_cmd_t         entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  logic do_push;
  logic do_pop;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign pop_cmd = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/gfp_front.sv
// ----------------------------------------------------------------------------
// gfp_front
// Input side: accept items, track a pending coordinate and turn each item
// into a command for the back sequencer, or drop it.
// ----------------------------------------------------------------------------
module gfp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [55:0]      s_axis_tdata,
  input  logic [2:0]       s_axis_tuser,
  input  logic             s_axis_tlast,
  input  logic             q_full,
  output logic             q_push,
  output gfp_pkg::fp_cmd_t q_cmd
);
  import gfp_pkg::*;

  logic [7:0] point_type_code;
  logic       awaiting_coord;
  logic       awaiting_coord_next;
  logic       accept;
  logic       cmd_valid;
  logic       coord_node;

  logic [31:0] item_id;
  logic [7:0]  item_kind;
  logic        has_coord;
  logic [7:0]  coord_byte;
  logic        byte_valid;

  assign item_id    = s_axis_tdata[31:0];
  assign item_kind  = s_axis_tdata[39:32];
  assign has_coord  = s_axis_tdata[40];
  assign coord_byte = s_axis_tdata[48:41];
  assign byte_valid = s_axis_tdata[49];

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign coord_node    = (item_kind == point_type_code) && has_coord;
  assign q_push        = accept && cmd_valid;

  always_comb begin
    q_cmd.code  = CMD_BEGIN;
    q_cmd.id    = item_id;
    q_cmd.kind  = item_kind;
    q_cmd.coord = coord_node;
    q_cmd.data  = coord_byte;
    q_cmd.mix   = byte_valid && (coord_byte != 8'd0);
    q_cmd.last  = s_axis_tlast;
    cmd_valid   = 1'b1;
    awaiting_coord_next = 1'b0;
    case (op_code_t'(s_axis_tuser))
      OP_BEGIN: begin
        q_cmd.code = CMD_BEGIN;
      end
      OP_NODE: begin
        q_cmd.code = CMD_NODE;
        awaiting_coord_next = coord_node;
      end
      OP_COORD: begin
        // drop a stray byte with no node waiting
        q_cmd.code = CMD_BYTE;
        cmd_valid  = awaiting_coord;
        awaiting_coord_next = awaiting_coord && !s_axis_tlast;
      end
      OP_CONSTRAINT: begin
        q_cmd.code = CMD_CONSTRAINT;
      end
      OP_FINISH: begin
        q_cmd.code = CMD_FINISH;
      end
      default: begin
        cmd_valid = 1'b0;
        awaiting_coord_next = awaiting_coord;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_type_code <= 8'd0;
      awaiting_coord  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        point_type_code <= cfg_wr_data;
      end
      if (accept) begin
        awaiting_coord <= awaiting_coord_next;
      end
    end
  end

endmodule

### sv/gfp_back.sv
// ----------------------------------------------------------------------------
// gfp_back
// Back sequencer: format ids and kinds as decimal text, hash one character
// a cycle, fold into the graph hash and drive the result register.
// ----------------------------------------------------------------------------
module gfp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  gfp_pkg::fp_cmd_t q_cmd,
  output logic             q_pop,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [79:0]      m_axis_tdata,
  output logic             m_axis_tuser
);
  import gfp_pkg::*;

  back_state_t state;
  back_state_t state_next;

  fp_cmd_t     cur;
  logic [63:0] work;
  logic [63:0] graph;
  logic [15:0] nodes;
  logic [31:0] val;
  logic [3:0]  dcnt;
  logic [3:0]  digits [10];
  logic        on_kind;

  logic        out_valid;
  logic        out_graph;
  logic [63:0] out_hash;
  logic [15:0] out_count;
  logic        out_free;
  logic        out_load;

  logic [31:0] id_mag;
  logic [63:0] prod;
  logic [31:0] quot;
  logic [31:0] tenq;
  logic [31:0] rem;
  logic [3:0]  dig_rd;

  logic [63:0] mix_h;
  logic [63:0] mix_x;
  logic [63:0] mix_r;

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign out_free = !out_valid || m_axis_tready;
  assign out_load = (state == ST_OUT) && out_free;

  assign id_mag = q_cmd.id[31] ? (32'd0 - q_cmd.id) : q_cmd.id;

  // divide by ten through the reciprocal
  assign prod = val * RECIP10;
  assign quot = {3'd0, prod[63:35]};
  assign tenq = {quot[28:0], 3'd0} + {quot[30:0], 1'b0};
  assign rem  = val - tenq;

  assign dig_rd = digits[dcnt - 4'd1];

  // one mix unit, shared by the character steps and the fold
  always_comb begin
    mix_h = work;
    mix_x = 64'd0;
    case (state)
      ST_IDLE:    mix_x = {56'd0, q_cmd.data};
      ST_CHAR_C:  mix_x = {56'd0, CH_C};
      ST_COLON_A: mix_x = {56'd0, CH_COLON};
      ST_MINUS:   mix_x = {56'd0, CH_MINUS};
      ST_DIGIT:   mix_x = {56'd0, CH_ZERO | {4'd0, dig_rd}};
      ST_SEP:     mix_x = {56'd0, CH_COLON};
      ST_TAIL:    mix_x = {56'd0, CH_COLON};
      ST_FOLD: begin
        mix_h = graph;
        mix_x = work;
      end
      default:    mix_x = 64'd0;
    endcase
  end

  assign mix_r = fnv_mix(mix_h, mix_x);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.code)
            CMD_NODE:       state_next = q_cmd.id[31] ? ST_MINUS : ST_DIV;
            CMD_CONSTRAINT: state_next = ST_CHAR_C;
            CMD_BYTE:       state_next = q_cmd.last ? ST_FOLD : ST_IDLE;
            CMD_FINISH:     state_next = ST_OUT;
            default:        state_next = ST_IDLE;
          endcase
        end
      end
      ST_CHAR_C:  state_next = ST_COLON_A;
      ST_COLON_A: state_next = cur.id[31] ? ST_MINUS : ST_DIV;
      ST_MINUS:   state_next = ST_DIV;
      ST_DIV:     state_next = (quot == 32'd0) ? ST_DIGIT : ST_DIV;
      ST_DIGIT: begin
        if (dcnt == 4'd1) begin
          if (!on_kind) begin
            state_next = ST_SEP;
          end else if (cur.code == CMD_NODE && cur.coord) begin
            state_next = ST_TAIL;
          end else begin
            state_next = ST_FOLD;
          end
        end
      end
      ST_SEP:     state_next = ST_DIV;
      ST_TAIL:    state_next = ST_IDLE;
      ST_FOLD:    state_next = (cur.code == CMD_CONSTRAINT) ? ST_IDLE : ST_OUT;
      ST_OUT:     state_next = out_free ? ST_IDLE : ST_OUT;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    // payload
    if (q_pop) begin
      cur <= q_cmd;
    end
    if (state == ST_DIV) begin
      digits[dcnt] <= rem[3:0];
    end
    if (out_load) begin
      out_graph <= (cur.code == CMD_FINISH);
      out_hash  <= (cur.code == CMD_FINISH) ? graph : work;
      out_count <= (cur.code == CMD_FINISH) ? nodes : 16'd0;
    end

    if (rst) begin
      state     <= ST_IDLE;
      work      <= FNV_BASIS;
      graph     <= FNV_BASIS;
      nodes     <= 16'd0;
      val       <= 32'd0;
      dcnt      <= 4'd0;
      on_kind   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_cmd.code)
              CMD_BEGIN: begin
                work  <= FNV_BASIS;
                graph <= FNV_BASIS;
                nodes <= 16'd0;
              end
              CMD_NODE, CMD_CONSTRAINT: begin
                work    <= FNV_BASIS;
                val     <= id_mag;
                dcnt    <= 4'd0;
                on_kind <= 1'b0;
              end
              CMD_BYTE: begin
                if (q_cmd.mix) begin
                  work <= mix_r;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_CHAR_C, ST_COLON_A, ST_MINUS, ST_TAIL: begin
          work <= mix_r;
        end
        ST_DIV: begin
          val  <= quot;
          dcnt <= dcnt + 4'd1;
        end
        ST_DIGIT: begin
          work <= mix_r;
          dcnt <= dcnt - 4'd1;
        end
        ST_SEP: begin
          work    <= mix_r;
          val     <= {24'd0, cur.kind};
          on_kind <= 1'b1;
        end
        ST_FOLD: begin
          graph <= mix_r;
          if (cur.code != CMD_CONSTRAINT && nodes < NODE_LIMIT) begin
            nodes <= nodes + 16'd1;
          end
        end
        default: begin
        end
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_count, out_hash};
  assign m_axis_tuser  = out_graph;

`ifndef SYNTHESIS
  a_digit_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (dcnt < 4'd10))
    else $error("decimal digit buffer overrun");

  a_digit_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIGIT) |-> (dcnt != 4'd0))
    else $error("digit emission with empty buffer");

  a_count_source: assert property (@(posedge clk) disable iff (rst)
    (nodes != $past(nodes)) |-> ($past(state) == ST_FOLD || $past(state) == ST_IDLE))
    else $error("node count changed outside fold or begin");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FOLD && nodes == NODE_LIMIT) |=> (nodes == NODE_LIMIT))
    else $error("node count passed its limit");
`endif

endmodule

### sv/graph_fingerprint_fnv1a_top.sv
// ----------------------------------------------------------------------------
// graph_fingerprint_fnv1a_top
// Streaming graph fingerprinter on 64-bit FNV-1a: node and constraint text
// hashing, graph fold and node count.
// ----------------------------------------------------------------------------
// A node item without a coordinate passes the command queue; the back sequencer
//   hashes a minus sign for a negative id, the id digits, a colon and the kind
//   digits, folds the node into the graph hash and loads the output register.
// Throughput: set by the back sequencer's one FNV mix unit and one
//   divide-by-ten step, each taking one character a cycle; the sequencer takes
//   a new command only when idle and holds in its output step while the
//   receiver stalls. Coordinate bytes are hashed as taken, the last one also
//   closing the node; constraints first hash "C:" and skip the output step.
// Reset (rst, synchronous): empty queue, no pending coordinate, graph hash at
//   the offset basis, node count zero, point type code zero.
// ----------------------------------------------------------------------------
module graph_fingerprint_fnv1a_top #(
  parameter int QUEUE_DEPTH = gfp_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: point type code
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0: item_id[31:0], item_kind[7:0], has_coord, coord_byte[7:0],
  //   byte_valid, zero fill[5:0]
  input  logic [55:0] s_axis_tdata,
  // tuser: operation[2:0]
  input  logic [2:0]  s_axis_tuser,
  // tlast: last_byte
  input  logic        s_axis_tlast,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata from bit 0: hash_value[63:0], node_total[15:0]
  output logic [79:0] m_axis_tdata,
  // tuser: result_kind
  output logic        m_axis_tuser
);
  import gfp_pkg::*;

  // command path between front and back
  logic    q_push;
  fp_cmd_t q_push_cmd;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  fp_cmd_t q_pop_cmd;

  // Front: classify each transfer, drop stray and unused items, hold the
  // pending-coordinate flag and the configuration register.
  gfp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_push_cmd)
  );

  // Queue: decouple input transfers from the character sequencer.
  gfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd)
  );

  // Back: format, hash, fold and hold each result in the output register
  // until transferred.
  gfp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_pop_cmd),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

### dv/graph_fingerprint_fnv1a_top_tb.sv
// ----------------------------------------------------------------------------
// graph_fingerprint_fnv1a_top_tb
// Self-checking bench for the FNV-1a graph fingerprinter. A local model hashes
// the node and constraint text and folds it into the graph hash. Each result
// transfer is compared with the oldest queued expectation. Directed checks
// cover the id and kind extremes and the coordinate corner cases. Random
// graphs follow under several point codes, with idle gaps, stalls and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module graph_fingerprint_fnv1a_top_tb;
  import gfp_pkg::*;

  localparam logic [63:0] FNV_PRIME_64    = 64'h00000100000001B3;
  localparam logic [2:0]  SPARE_OP_FIRST  = 3'd5;
  localparam logic [2:0]  SPARE_OP_LAST   = 3'd7;
  // longest node text plus the command queue, with margin
  localparam int          SETTLE_CYCLES   = 48;
  localparam int          HOLD_OFF_CYCLES = 400;
  localparam int          LIMIT_CYCLES    = 1500000;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] id;
    logic [7:0]  kind;
    logic        has_coord;
    logic [7:0]  cbyte;
    logic        bvalid;
    logic        last;
  } stim_item_t;

  typedef struct {
    logic        kind;
    logic [63:0] hash;
    logic [15:0] total;
  } fp_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tuser;

  // model state
  logic [7:0]  point_code;
  logic [63:0] model_graph;
  logic [63:0] node_hash;
  logic [15:0] model_nodes;
  logic        coord_pending;
  fp_result_t  hash_expect_q[$];

  // run control and statistics
  int mismatches;
  int cycle_count;
  int items_effective;
  int node_results;
  int graph_results;
  int input_stall_cycles;
  bit tx_idle_on;
  bit rx_idle_on;
  int rx_hold;

  graph_fingerprint_fnv1a_top DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               hash_expect_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // FNV-1a arithmetic
  // --------------------------------------------------------------------------
  function automatic logic [63:0] fnv_byte(input logic [63:0] h, input logic [7:0] b);
    return (h ^ {56'd0, b}) * FNV_PRIME_64;
  endfunction

  // Unsigned decimal text, most significant digit first.
  function automatic logic [63:0] fnv_decimal(input logic [63:0] h, input logic [31:0] v);
    logic [7:0] digits [10];
    int         n;
    n = 0;
    while (n == 0 || v != 0) begin
      digits[n] = CH_ZERO + 8'(v % 10);
      v = v / 10;
      n++;
    end
    for (int i = n - 1; i >= 0; i--) h = fnv_byte(h, digits[i]);
    return h;
  endfunction

  function automatic logic [63:0] fnv_signed(input logic [63:0] h, input logic [31:0] v);
    if (v[31]) begin
      h = fnv_byte(h, CH_MINUS);
      v = -v;
    end
    return fnv_decimal(h, v);
  endfunction

  // Fold the finished node into the graph and queue its node result.
  task automatic close_node();
    model_graph = (model_graph ^ node_hash) * FNV_PRIME_64;
    if (model_nodes < NODE_LIMIT) model_nodes++;
    coord_pending = 1'b0;
    hash_expect_q.push_back('{1'b0, node_hash, 16'd0});
  endtask

  // Advance the model by one accepted input transfer.
  task automatic fingerprint_predict(input stim_item_t it);
    logic [63:0] h;
    case (it.op)
      OP_BEGIN: begin
        model_graph   = FNV_BASIS;
        node_hash     = FNV_BASIS;
        model_nodes   = 16'd0;
        coord_pending = 1'b0;
      end
      OP_NODE: begin
        coord_pending = 1'b0;
        h = fnv_signed(FNV_BASIS, it.id);
        h = fnv_byte(h, CH_COLON);
        h = fnv_decimal(h, {24'd0, it.kind});
        if (it.kind == point_code && it.has_coord) begin
          // hold the node open until the coordinate ends
          node_hash     = fnv_byte(h, CH_COLON);
          coord_pending = 1'b1;
        end else begin
          node_hash = h;
          close_node();
        end
      end
      OP_COORD: begin
        if (!coord_pending) begin
          items_effective--;  // stray byte, dropped by the block
        end else begin
          if (it.bvalid && it.cbyte != 8'd0) node_hash = fnv_byte(node_hash, it.cbyte);
          if (it.last) close_node();
        end
      end
      OP_CONSTRAINT: begin
        coord_pending = 1'b0;
        h = fnv_byte(FNV_BASIS, CH_C);
        h = fnv_byte(h, CH_COLON);
        h = fnv_signed(h, it.id);
        h = fnv_byte(h, CH_COLON);
        h = fnv_decimal(h, {24'd0, it.kind});
        model_graph = (model_graph ^ h) * FNV_PRIME_64;
      end
      OP_FINISH: begin
        coord_pending = 1'b0;
        hash_expect_q.push_back('{1'b1, model_graph, model_nodes});
      end
      default: items_effective--;  // spare codes are ignored, pending node kept
    endcase
    items_effective++;
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[cycle %0d] %s: got %0h, expected %0h", cycle_count, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    fp_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (hash_expect_q.size() == 0) begin
        report_mismatch("result with nothing expected", m_axis_tdata[63:0], 64'd0);
      end else begin
        want = hash_expect_q.pop_front();
        if (m_axis_tuser !== want.kind)
          report_mismatch("result kind", {63'd0, m_axis_tuser}, {63'd0, want.kind});
        if (m_axis_tdata[63:0] !== want.hash)
          report_mismatch("hash value", m_axis_tdata[63:0], want.hash);
        if (m_axis_tdata[79:64] !== want.total)
          report_mismatch("node total", {48'd0, m_axis_tdata[79:64]}, {48'd0, want.total});
        if (want.kind) graph_results++;
        else node_results++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Idle gaps: mostly short, now and then long
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // Receiver: honour a requested hold-off first, then random stalls.
  initial begin : result_sink
    int gap;
    gap = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold--;
      end else if (gap > 0) begin
        m_axis_tready <= 1'b0;
        gap--;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_idle_on && $urandom_range(99) < 20) gap = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Offer one item, hold it until the transfer, then at times idle for a while.
  task automatic send_item(input stim_item_t it);
    int gap;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, it.bvalid, it.cbyte, it.has_coord, it.kind, it.id};
    s_axis_tuser  <= it.op;
    s_axis_tlast  <= it.last;
    @(posedge clk);
    while (!s_axis_tready) begin
      input_stall_cycles++;
      @(posedge clk);
    end
    fingerprint_predict(it);
    gap = (tx_idle_on && $urandom_range(99) < 40) ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic stim_item_t make_op(input logic [2:0] op, input logic [31:0] id,
                                         input logic [7:0] kind, input logic has_coord,
                                         input logic [7:0] cbyte, input logic bvalid,
                                         input logic last);
    return '{op, id, kind, has_coord, cbyte, bvalid, last};
  endfunction

  // Ids lean on short numbers, signs and the 32-bit extremes.
  function automatic logic [31:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 15) return $urandom_range(99);
    if (r < 25) return -$urandom_range(99, 1);
    if (r < 30) return 32'h7FFFFFFF;
    if (r < 35) return 32'h80000000;
    if (r < 40) return 32'hFFFFFFFF;
    return $urandom;
  endfunction

  // Every field random, so the don't-care bits toggle too.
  function automatic stim_item_t make_item(input logic [2:0] op);
    return '{op, pick_id(), 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
             1'($urandom)};
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (hash_expect_q.size() != 0) @(posedge clk);
    // constraints and begins leave no trace: let the back end finish
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_point_code(input logic [7:0] code);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= code;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    point_code = code;
  endtask

  // Coordinate bytes after an open node; a broken one is never terminated.
  task automatic send_coordinate(input bit broken);
    stim_item_t it;
    int         nbytes;
    nbytes = ($urandom_range(19) == 0) ? $urandom_range(40, 13) : $urandom_range(12);
    repeat (nbytes) begin
      if ($urandom_range(29) == 0)
        send_item(make_item(3'($urandom_range(SPARE_OP_LAST, SPARE_OP_FIRST))));
      it        = make_item(OP_COORD);
      it.bvalid = ($urandom_range(9) != 0);
      it.cbyte  = ($urandom_range(14) == 0) ? 8'd0 : 8'($urandom_range(126, 32));
      it.last   = 1'b0;
      send_item(it);
    end
    if (!broken) begin
      it        = make_item(OP_COORD);
      it.bvalid = ($urandom_range(4) != 0);
      it.last   = 1'b1;
      send_item(it);
    end
  endtask

  // Id and kind extremes, constraints, ignored codes, finish.
  task automatic test_text_extremes();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_item(make_op(OP_BEGIN, 32'd0, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0));
    send_item(make_op(OP_NODE, 32'd0, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0));
    send_item(make_op(OP_NODE, 32'h7FFFFFFF, 8'hFF, 1'b0, 8'hFF, 1'b1, 1'b1));
    send_item(make_op(OP_NODE, 32'h80000000, 8'd9, 1'b0, 8'd0, 1'b0, 1'b0));
    send_item(make_op(OP_NODE, 32'hFFFFFFFF, 8'd10, 1'b0, 8'd0, 1'b0, 1'b0));
    send_item(make_op(OP_CONSTRAINT, 32'd123, 8'd200, 1'b0, 8'd0, 1'b0, 1'b0));
    send_item(make_op(OP_CONSTRAINT, 32'h80000000, 8'd0, 1'b1, 8'd0, 1'b0, 1'b0));
    send_item(make_op(OP_COORD, 32'd5, 8'd0, 1'b0, 8'h41, 1'b1, 1'b1));
    send_item(make_op(SPARE_OP_FIRST, 32'd1, 8'd1, 1'b1, 8'h41, 1'b1, 1'b1));
    send_item(make_op(SPARE_OP_LAST, 32'd2, 8'd2, 1'b0, 8'h42, 1'b0, 1'b0));
    send_item(make_op(OP_FINISH, 32'd0, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0));
  endtask

  // Coordinate text: zero and absent bytes, empty string, unfinished nodes,
  // a node of another kind, accumulation after finish.
  task automatic test_coordinates();
    write_point_code(8'd0);
    send_item(make_op(OP_NODE, 32'd42, 8'd0, 1'b1, 8'd0, 1'b0, 1'b0));
    send_item(make_op(OP_COORD, 32'd0, 8'd0, 1'b0, 8'h41, 1'b1, 1'b0));
    send_item(make_op(OP_COORD, 32'd0, 8'd0, 1'b0, 8'h00, 1'b1, 1'b0));
    send_item(make_op(OP_COORD, 32'd0, 8'd0, 1'b0, 8'hFF, 1'b0, 1'b0));
    send_item(make_op(3'd6, 32'd0, 8'd0, 1'b0, 8'h33, 1'b1, 1'b1));
    send_item(make_op(OP_COORD, 32'd0, 8'd0, 1'b0, 8'h80, 1'b1, 1'b1));
    send_item(make_op(OP_NODE, -32'sd5, 8'd0, 1'b1, 8'd0, 1'b0, 1'b0));
    send_item(make_op(OP_COORD, 32'd0, 8'd0, 1'b0, 8'h00, 1'b0, 1'b1));
    send_item(make_op(OP_NODE, 32'd7, 8'd0, 1'b1, 8'd0, 1'b0, 1'b0));
    send_item(make_op(OP_COORD, 32'd0, 8'd0, 1'b0, 8'h78, 1'b1, 1'b0));
    send_item(make_op(OP_NODE, 32'd8, 8'd3, 1'b1, 8'd0, 1'b0, 1'b0));
    send_item(make_op(OP_NODE, 32'd9, 8'd0, 1'b1, 8'd0, 1'b0, 1'b0));
    send_item(make_op(OP_FINISH, 32'd0, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0));
    send_item(make_op(OP_COORD, 32'd0, 8'd0, 1'b0, 8'h31, 1'b1, 1'b1));
    send_item(make_op(OP_CONSTRAINT, 32'd1, 8'd1, 1'b0, 8'd0, 1'b0, 1'b0));
    send_item(make_op(OP_FINISH, 32'd0, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0));
  endtask

  // Random graphs: mostly well formed, with dropped nodes and noise mixed in.
  task automatic test_random_graphs(input int target, input logic [7:0] code,
                                    input bit tx_idle, input bit rx_idle);
    stim_item_t it;
    int         stop_at;
    int         r;
    write_point_code(code);
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    stop_at = items_effective + target;
    while (items_effective < stop_at) begin
      if ($urandom_range(9) != 0) send_item(make_item(OP_BEGIN));
      repeat ($urandom_range(14, 1)) begin
        r = $urandom_range(99);
        if (r < 60) begin
          it           = make_item(OP_NODE);
          it.has_coord = ($urandom_range(2) != 0);
          if ($urandom_range(1)) it.kind = point_code;
          send_item(it);
          if (it.has_coord && it.kind == point_code) send_coordinate(r >= 54);
        end else if (r < 80) begin
          send_item(make_item(OP_CONSTRAINT));
        end else if (r < 88) begin
          send_item(make_item(OP_COORD));
        end else if (r < 94) begin
          send_item(make_item(OP_FINISH));
        end else begin
          send_item(make_item(3'($urandom_range(SPARE_OP_LAST, SPARE_OP_FIRST))));
        end
      end
      send_item(make_item(OP_FINISH));
    end
  endtask

  // Hold the receiver off while nodes stream in back to back, so the block
  // fills and stalls its input; then pause until every result is home.
  task automatic test_backpressure();
    stim_item_t it;
    wait_idle();
    tx_idle_on = 1'b0;
    rx_hold    = HOLD_OFF_CYCLES;
    repeat (40) begin
      it           = make_item(OP_NODE);
      it.has_coord = 1'b0;
      send_item(it);
    end
    send_item(make_item(OP_FINISH));
    wait_idle();
  endtask

  initial begin
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = 8'd0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = '0;
    s_axis_tlast    = 1'b0;
    mismatches      = 0;
    items_effective = 0;
    node_results    = 0;
    graph_results   = 0;
    input_stall_cycles = 0;
    tx_idle_on      = 1'b0;
    rx_idle_on      = 1'b0;
    rx_hold         = 0;
    // model follows the block's reset values
    point_code      = 8'd0;
    model_graph     = FNV_BASIS;
    node_hash       = FNV_BASIS;
    model_nodes     = 16'd0;
    coord_pending   = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_text_extremes();
    test_coordinates();
    test_random_graphs(450, 8'hFF, 1'b1, 1'b1);
    test_backpressure();
    test_random_graphs(450, 8'($urandom), 1'b0, 1'b1);
    test_random_graphs(450, 8'd0, 1'b1, 1'b0);
    test_random_graphs(450, 8'($urandom_range(254, 1)), 1'b1, 1'b1);
    wait_idle();

    $display("covered %0d hashed items, %0d node and %0d graph results checked",
             items_effective, node_results, graph_results);
    $display("input held off for %0d cycles, %0d mismatches, %0d cycles",
             input_stall_cycles, mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
sv/gfp_pkg.sv
sv/gfp_queue.sv
sv/gfp_front.sv
sv/gfp_back.sv
sv/graph_fingerprint_fnv1a_top.sv
dv/graph_fingerprint_fnv1a_top_tb.sv
